// File: sv/ttsch_pkg.sv
// types, sizes and codes shared by the timed task scheduler
// no dependencies
`timescale 1ns / 1ps

package ttsch_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TIME_W   = 32;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_POLL     = 2'd1,
        OP_CLEAR    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FIRED = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [3:0]        handler;
        logic [7:0]        stop_id;
        logic [7:0]        start_id;
        logic [TIME_W-1:0] stop_delay;
        logic [TIME_W-1:0] every;
        logic [TIME_W-1:0] due;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quot;
        logic [TIME_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: sv/ttsch_div.sv
// restoring divider, one quotient bit per cycle
// depends on ttsch_pkg
`timescale 1ns / 1ps

module ttsch_div
    import ttsch_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(TIME_W + 1);

    logic [TIME_W:0]   r_rem,  n_rem;
    logic [TIME_W-1:0] r_quot, n_quot;
    logic [TIME_W-1:0] r_den,  n_den;
    logic [CW-1:0]     r_cnt,  n_cnt;
    logic              r_done, n_done;
    logic [TIME_W:0]   w_shift;
    logic [TIME_W:0]   w_trial;

    assign w_shift = {r_rem[TIME_W-1:0], r_quot[TIME_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quot = i_req.num;
            n_den  = i_req.den;
            n_cnt  = CW'(TIME_W);
        end else if (r_cnt != '0) begin
            if (!w_trial[TIME_W]) begin
                n_rem  = w_trial;
                n_quot = {r_quot[TIME_W-2:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_quot = {r_quot[TIME_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_den  <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[TIME_W-1:0];

endmodule

// File: sv/timed_task_scheduler.sv
// timed task scheduler: task table in one memory, scan and update sequencer
// depends on ttsch_pkg, ttsch_div
//
//  channel | direction | tuser     | tdata
//  s       | in        | operation | now_ms, start_time, period, run_length, ids, handler
//  m       | out       | status    | event_id, fired_handler, wait_ms
//
// register, clear and an empty poll go straight to the result; a poll scans every entry
// and then evaluates the earliest, writes a fired periodic task back, through the divider
// when it skips missed periods, and moves each later entry down one place when a
// one-shot task leaves the table. the memory port serializes the scan and the move.
// reset clears the control state, the count and the result valid only; the result register
// holds its item under a stall and the next item waits at the input.
`timescale 1ns / 1ps

module timed_task_scheduler
    import ttsch_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [151:0] i_s_tdata,  // now_ms, start_time, period, run_length,
                                     // start_id, stop_id, handler, zero pad
    input  logic [1:0]   i_s_tuser,  // operation
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,  // event_id, fired_handler, wait_ms, zero pad
    output logic [1:0]   o_m_tuser   // status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_EVAL, S_DIV, S_MUL, S_WB, S_SH_RD, S_SH_WR, S_STOP, S_OUT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  r_best_idx;
    t_entry            r_best;
    t_entry            r_rdata;
    t_entry            mem [CAPACITY];
    logic [TIME_W-1:0] r_now;
    t_entry            r_in;
    logic [1:0]        r_op;
    t_status           r_status;
    logic [7:0]        r_ev;
    logic [3:0]        r_tgt;
    logic [TIME_W-1:0] r_wait;
    logic [TIME_W-1:0] r_prod;
    logic              r_ov;
    logic [7:0]        r_o_ev;
    logic [3:0]        r_o_tgt;
    logic [TIME_W-1:0] r_o_wait;
    t_status           r_o_status;

    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_we;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    logic [TIME_W:0]   w_first;
    logic [TIME_W-1:0] w_steps;
    logic [CNT_W-1:0]  w_k1;
    t_entry            w_new;
    t_entry            w_stop;

    ttsch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_first    = {1'b0, r_best.due} + {1'b0, r_best.every};
    assign w_steps    = w_div_rsp.quot + TIME_W'(w_div_rsp.rem != '0);
    assign w_k1       = CNT_W'(r_k) + CNT_W'(1);

    assign w_new.due        = i_s_tdata[63:32];
    assign w_new.every      = i_s_tdata[95:64];
    assign w_new.stop_delay = i_s_tdata[127:96];
    assign w_new.start_id   = i_s_tdata[135:128];
    assign w_new.stop_id    = i_s_tdata[143:136];
    assign w_new.handler    = i_s_tdata[147:144];

    always_comb begin
        w_stop            = '0;
        w_stop.due        = r_now + r_best.stop_delay;
        w_stop.start_id   = r_best.stop_id;
        w_stop.handler    = r_best.handler;
    end

    always_comb begin
        w_rd_addr = '0;
        if (r_state == S_SCAN) begin
            w_rd_addr = w_k1[IDX_W-1:0];
        end else if (r_state == S_SH_RD) begin
            w_rd_addr = w_k1[IDX_W-1:0];
        end
    end

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_count[IDX_W-1:0];
        w_wr_data = r_in;
        case (r_state)
            S_WB: begin
                w_we      = 1'b1;
                w_wr_addr = r_best_idx;
                w_wr_data = r_best;
            end
            S_SH_WR: begin
                w_we      = 1'b1;
                w_wr_addr = r_k;
                w_wr_data = r_rdata;
            end
            S_STOP: begin
                w_we      = (r_best.stop_delay != '0) && (r_count < CNT_W'(CAPACITY));
                w_wr_data = w_stop;
            end
            S_EVAL: begin
                w_we = 1'b0;
            end
            default: begin
                w_we = (r_state == S_OUT) && (r_op == OP_REGISTER)
                       && (r_status == ST_IDLE) && 1'b0;
            end
        endcase
        if (r_state == S_IDLE && i_s_tvalid && i_s_tuser == OP_REGISTER
                && r_count < CNT_W'(CAPACITY)) begin
            w_we      = 1'b1;
            w_wr_data = w_new;
        end
    end

    always_comb begin
        w_div_req       = '0;
        w_div_req.num   = r_now - r_best.due;
        w_div_req.den   = r_best.every;
        w_div_req.start = (r_state == S_EVAL) && (r_best.due <= r_now)
                          && (r_best.every != '0) && !w_first[TIME_W]
                          && ({1'b0, r_now} > w_first)
                          && (w_first > {1'b0, r_best.every});
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[w_rd_addr];
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_m_tready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op     <= i_s_tuser;
                        r_now    <= i_s_tdata[31:0];
                        r_ev     <= '0;
                        r_tgt    <= '0;
                        r_wait   <= '0;
                        r_k      <= '0;
                        case (i_s_tuser)
                            OP_REGISTER: begin
                                r_state <= S_OUT;
                                if (r_count < CNT_W'(CAPACITY)) begin
                                    r_count  <= r_count + CNT_W'(1);
                                    r_status <= ST_IDLE;
                                end else begin
                                    r_status <= ST_FULL;
                                end
                            end
                            OP_POLL: begin
                                if (r_count == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_status <= ST_IDLE;
                                    r_state  <= S_SCAN;
                                end
                            end
                            OP_CLEAR: begin
                                r_count  <= '0;
                                r_status <= ST_IDLE;
                                r_state  <= S_OUT;
                            end
                            default: begin
                                r_status <= ST_IDLE;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_k == '0 || r_rdata.due < r_best.due) begin
                        r_best     <= r_rdata;
                        r_best_idx <= r_k;
                    end
                    if (w_k1 == r_count) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_k <= w_k1[IDX_W-1:0];
                    end
                end
                S_EVAL: begin
                    if (r_best.due > r_now) begin
                        r_wait  <= r_best.due - r_now;
                        r_state <= S_OUT;
                    end else begin
                        r_status <= ST_FIRED;
                        r_ev     <= r_best.start_id;
                        r_tgt    <= r_best.handler;
                        if (r_best.every != '0) begin
                            if (w_div_req.start) begin
                                r_state <= S_DIV;
                            end else begin
                                r_best.due <= w_first[TIME_W-1:0];
                                r_state    <= S_WB;
                            end
                        end else begin
                            r_k <= r_best_idx;
                            if (CNT_W'(r_best_idx) + CNT_W'(1) < r_count) begin
                                r_state <= S_SH_RD;
                            end else begin
                                r_count <= r_count - CNT_W'(1);
                                r_state <= S_STOP;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_prod  <= TIME_W'(w_steps * r_best.every);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_best.due <= r_best.due + r_prod;
                    r_state    <= S_WB;
                end
                S_WB: r_state <= S_STOP;
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_k <= w_k1[IDX_W-1:0];
                    if (w_k1 + CNT_W'(1) < r_count) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_STOP;
                    end
                end
                S_STOP: begin
                    if (w_we) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || i_m_tready) begin
                        r_ov       <= 1'b1;
                        r_o_status <= r_status;
                        r_o_ev     <= r_ev;
                        r_o_tgt    <= r_tgt;
                        r_o_wait   <= r_wait;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_in <= w_new;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {4'b0, r_o_wait, r_o_tgt, r_o_ev};

endmodule

// File: sv/ttsch_checker.sv
// port-level checks for the timed task scheduler, bound to the top level
// depends on ttsch_pkg
`timescale 1ns / 1ps

module ttsch_checker
    import ttsch_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // one item at a time
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while busy");

    // only a fired result carries an event
    a_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_FIRED |-> o_m_tdata[11:0] == '0)
        else $error("event fields set without fire");

    // wait only with nothing due
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_IDLE |-> o_m_tdata[43:12] == '0)
        else $error("wait set on non-idle status");

endmodule

bind timed_task_scheduler ttsch_checker u_ttsch_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
